FILE: sv/greedy_line_breaker_defines.svh
// Assertion macros for the greedy line breaker checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef GREEDY_LINE_BREAKER_DEFINES_SVH
`define GREEDY_LINE_BREAKER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define GLB_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define GLB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/glb_pkg.sv
// Shared types, constants and helper functions for the greedy line breaker.
// No dependencies; imported by every module of the block.
package glb_pkg;

    localparam int GLB_MAX_LINE_STARTS = 2048;
    localparam int GLB_MAX_TEXT_LENGTH = 32767;
    localparam int GLB_TAB_SPACES      = 8;

    localparam int CHAR_W    = 8;
    localparam int SPACE_W   = 8;
    localparam int MAXW_W    = 15;
    localparam int LINE_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 15;

    localparam int GLB_FIFO_DEPTH = 2;

    localparam logic [CHAR_W-1:0] CODE_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CODE_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CODE_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CODE_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0] CODE_COMMA = 8'd44;
    localparam logic [CHAR_W-1:0] CODE_DASH  = 8'd45;
    localparam logic [CHAR_W-1:0] CODE_DOT   = 8'd46;
    localparam logic [CHAR_W-1:0] CODE_SLASH = 8'd47;
    localparam logic [CHAR_W-1:0] CODE_COLON = 8'd58;
    localparam logic [CHAR_W-1:0] CODE_SEMI  = 8'd59;
    localparam logic [CHAR_W-1:0] CODE_BSLASH = 8'd92;

    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACE_WIDTH = 2'd2;

    localparam logic               WRAP_RESET  = 1'b1;
    localparam logic [MAXW_W-1:0]  MAXW_RESET  = 15'd32767;
    localparam logic [SPACE_W-1:0] SPACE_RESET = 8'd7;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_COUNT = 1'b1;

    typedef struct packed {
        logic              is_cr;
        logic              is_lf;
        logic              is_tab;
        logic              is_brk;
        logic [CHAR_W-1:0] width;
        logic              eot;
    } glb_item_t;

    function automatic logic is_break_char(input logic [CHAR_W-1:0] c);
        case (c)
            CODE_SPACE, CODE_TAB, CODE_DASH, CODE_SLASH, CODE_BSLASH,
            CODE_COMMA, CODE_SEMI, CODE_COLON, CODE_DOT: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [LINE_W-1:0] sat_line_width(input logic [LINE_W:0] v);
        return v[LINE_W] ? {LINE_W{1'b1}} : v[LINE_W-1:0];
    endfunction

endpackage

FILE: sv/glb_front.sv
// Front end: accepts character beats and classifies them into queue items.
// Depends on glb_pkg.
module glb_front (
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [glb_pkg::CHAR_W-1:0] char_code,
    input  logic [glb_pkg::CHAR_W-1:0] char_width,
    input  logic                      end_of_text,
    input  logic                      fifo_full,
    output logic                      push,
    output glb_pkg::glb_item_t        push_item
);
    import glb_pkg::*;

    assign in_ready = !fifo_full;
    assign push     = in_valid && !fifo_full;

    always_comb
    begin
        push_item.is_cr  = (char_code == CODE_CR);
        push_item.is_lf  = (char_code == CODE_LF);
        push_item.is_tab = (char_code == CODE_TAB);
        push_item.is_brk = is_break_char(char_code);
        push_item.width  = char_width;
        push_item.eot    = end_of_text;
    end

endmodule

FILE: sv/glb_fifo.sv
// Short queue of classified items between front end and back end.
// Depends on glb_pkg.
module glb_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  glb_pkg::glb_item_t push_item,
    output logic               full,
    input  logic               pop,
    output glb_pkg::glb_item_t pop_item,
    output logic               empty
);
    import glb_pkg::*;

    localparam int AW = $clog2(GLB_FIFO_DEPTH);

    glb_item_t       entries_reg [GLB_FIFO_DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [AW:0]     count_reg, count_next;

    assign full     = (count_reg == (AW+1)'(GLB_FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (AW+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (AW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: sv/glb_tab_div.sv
// Bit-serial remainder unit for tab stops: one quotient bit per cycle.
// Depends on glb_pkg.
module glb_tab_div #(
    parameter int STEP_W = 11
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [glb_pkg::LINE_W-1:0] x,
    input  logic [STEP_W-1:0]         step,
    output logic                      done,
    output logic [STEP_W-1:0]         rem
);
    import glb_pkg::*;

    localparam int CNT_W = $clog2(LINE_W);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [LINE_W-1:0]   xs_reg;
    logic [STEP_W-1:0]   rem_reg;
    logic [STEP_W:0]     trial;
    logic [STEP_W:0]     diff;
    logic [STEP_W-1:0]   rem_next;

    assign trial    = {rem_reg, xs_reg[LINE_W-1]};
    assign diff     = trial - {1'b0, step};
    assign rem_next = (trial >= {1'b0, step}) ? diff[STEP_W-1:0] : trial[STEP_W-1:0];
    assign done     = done_reg;
    assign rem      = rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(LINE_W - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - CNT_W'(1);
            busy_reg <= (cnt_reg != '0);
            done_reg <= (cnt_reg == '0);
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            xs_reg  <= x;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            xs_reg  <= {xs_reg[LINE_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

endmodule

FILE: sv/glb_back.sv
// Back end: line-breaking state, tab-stop sequencing, result output register.
// Depends on glb_pkg and glb_tab_div.
module glb_back #(
    parameter int MAX_LINE_STARTS = glb_pkg::GLB_MAX_LINE_STARTS,
    parameter int MAX_TEXT_LENGTH = glb_pkg::GLB_MAX_TEXT_LENGTH,
    parameter int TAB_SPACES      = glb_pkg::GLB_TAB_SPACES
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  glb_pkg::glb_item_t                       head,
    input  logic                                     empty,
    output logic                                     pop,
    input  logic                                     cfg_write,
    input  logic [glb_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  logic [glb_pkg::CFG_W-1:0]                cfg_data,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic                                     kind,
    output logic [$clog2(MAX_TEXT_LENGTH+1)-1:0]     line_start,
    output logic [$clog2(MAX_LINE_STARTS)-1:0]       line_number,
    output logic [$clog2(MAX_LINE_STARTS+1)-1:0]     line_count,
    output logic                                     last
);
    import glb_pkg::*;

    localparam int PW    = $clog2(MAX_TEXT_LENGTH + 1);
    localparam int NW    = $clog2(MAX_LINE_STARTS);
    localparam int CW    = $clog2(MAX_LINE_STARTS + 1);
    localparam int SW    = $clog2((2**SPACE_W - 1) * TAB_SPACES + 1);
    localparam int SUM_W = LINE_W + 1;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_DIV0 = 6'b000010,
        ST_CHK1 = 6'b000100,
        ST_DIV1 = 6'b001000,
        ST_CHK2 = 6'b010000,
        ST_EMIT = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    logic               wrap_reg, wrap_next;
    logic [MAXW_W-1:0]  max_width_reg, max_width_next;
    logic [SPACE_W-1:0] space_reg, space_next;

    logic [PW-1:0]      pos_reg, pos_next;
    logic [LINE_W-1:0]  lw_reg, lw_next;
    logic [LINE_W-1:0]  wsb_reg, wsb_next;
    logic [PW-1:0]      lbp_reg, lbp_next;
    logic [PW-1:0]      cls_reg, cls_next;
    logic               pending_reg, pending_next;
    logic [CW-1:0]      lines_reg, lines_next;
    logic               rep_s_reg, rep_s_next;
    logic               rep_b1_reg, rep_b1_next;
    logic               rep_b2_reg, rep_b2_next;
    logic               out_valid_reg, out_valid_next;

    glb_item_t          it_reg, it_next;
    logic [PW-1:0]      cur_pos_reg, cur_pos_next;
    logic [PW-1:0]      b1_pos_reg, b1_pos_next;
    logic [SW-1:0]      cw_reg, cw_next;
    logic               kind_reg, kind_next;
    logic [PW-1:0]      start_reg, start_next;
    logic [NW-1:0]      number_reg, number_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               last_reg, last_next;
    logic               out_load;

    logic               div_start;
    logic [LINE_W-1:0]  div_x;
    logic               div_done;
    logic [SW-1:0]      div_rem;

    logic [SW-1:0]      step_raw;
    logic [SW-1:0]      step;
    logic [SUM_W-1:0]   width_sum;
    logic               over_max;
    logic               cond1;
    logic               cond2;
    logic [SW-1:0]      cw_restart;
    logic [SW-1:0]      cw_eff;
    logic [LINE_W-1:0]  lw_base;
    logic [LINE_W-1:0]  wsb_base;
    logic [SUM_W-1:0]   lw_sum;
    logic [SUM_W-1:0]   wsb_sum;
    logic               slot_free;
    logic               any_rep;
    logic [PW-1:0]      sel_pos;
    logic               sel_later;

    glb_tab_div #(
        .STEP_W (SW)
    ) u_tab_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .x     (div_x),
        .step  (step),
        .done  (div_done),
        .rem   (div_rem)
    );

    assign step_raw   = SW'(space_reg) * SW'(TAB_SPACES);
    assign step       = (step_raw == '0) ? SW'(7 * TAB_SPACES) : step_raw;
    assign width_sum  = {1'b0, lw_reg} + SUM_W'(cw_reg);
    assign over_max   = width_sum > SUM_W'(max_width_reg);
    assign cond1      = wrap_reg && (cur_pos_reg != cls_reg) && over_max &&
                        (lbp_reg > cls_reg);
    assign cond2      = wrap_reg && (cur_pos_reg != cls_reg) && over_max;
    assign cw_restart = it_reg.is_tab ? step : SW'(it_reg.width);
    assign cw_eff     = cond2 ? cw_restart : cw_reg;
    assign lw_base    = cond2 ? '0 : lw_reg;
    assign wsb_base   = cond2 ? '0 : wsb_reg;
    assign lw_sum     = {1'b0, lw_base} + SUM_W'(cw_eff);
    assign wsb_sum    = {1'b0, wsb_base} + SUM_W'(cw_eff);
    assign slot_free  = !out_valid_reg || out_ready;
    assign any_rep    = rep_s_reg || rep_b1_reg || rep_b2_reg;

    always_comb
    begin
        if (rep_s_reg)
        begin
            sel_pos   = cur_pos_reg;
            sel_later = rep_b1_reg || rep_b2_reg;
        end
        else if (rep_b1_reg)
        begin
            sel_pos   = b1_pos_reg;
            sel_later = rep_b2_reg;
        end
        else
        begin
            sel_pos   = cur_pos_reg;
            sel_later = 1'b0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        wrap_next      = wrap_reg;
        max_width_next = max_width_reg;
        space_next     = space_reg;
        pos_next       = pos_reg;
        lw_next        = lw_reg;
        wsb_next       = wsb_reg;
        lbp_next       = lbp_reg;
        cls_next       = cls_reg;
        pending_next   = pending_reg;
        lines_next     = lines_reg;
        rep_s_next     = rep_s_reg;
        rep_b1_next    = rep_b1_reg;
        rep_b2_next    = rep_b2_reg;
        out_valid_next = out_valid_reg && !out_ready;
        it_next        = it_reg;
        cur_pos_next   = cur_pos_reg;
        b1_pos_next    = b1_pos_reg;
        cw_next        = cw_reg;
        kind_next      = KIND_START;
        start_next     = '0;
        number_next    = '0;
        count_next     = '0;
        last_next      = 1'b0;
        out_load       = 1'b0;
        pop            = 1'b0;
        div_start      = 1'b0;
        div_x          = lw_reg;

        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_WRAP_ENABLE: wrap_next      = cfg_data[0];
                CFG_MAX_WIDTH:   max_width_next = cfg_data[MAXW_W-1:0];
                CFG_SPACE_WIDTH: space_next     = cfg_data[SPACE_W-1:0];
                default:         ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    pop          = 1'b1;
                    it_next      = head;
                    cur_pos_next = pos_reg;
                    cw_next      = SW'(head.width);
                    rep_s_next   = 1'b0;
                    rep_b1_next  = 1'b0;
                    rep_b2_next  = 1'b0;
                    state_next   = ST_EMIT;
                    if (pos_reg < PW'(MAX_TEXT_LENGTH))
                    begin
                        pos_next = pos_reg + PW'(1);
                        if (pending_reg)
                        begin
                            rep_s_next   = 1'b1;
                            pending_next = 1'b0;
                        end
                        if (head.is_cr)
                        begin
                            cls_next     = pos_reg + PW'(1);
                            lbp_next     = pos_reg + PW'(1);
                            lw_next      = '0;
                            wsb_next     = '0;
                            pending_next = 1'b1;
                        end
                        else if (wrap_reg && head.is_lf)
                        begin
                            if (pos_reg != cls_reg)
                            begin
                                rep_b1_next = 1'b1;
                                b1_pos_next = pos_reg;
                                cls_next    = pos_reg;
                                lbp_next    = pos_reg;
                                lw_next     = '0;
                                wsb_next    = '0;
                            end
                        end
                        else if (head.is_tab)
                        begin
                            div_start  = 1'b1;
                            div_x      = lw_reg;
                            state_next = ST_DIV0;
                        end
                        else
                        begin
                            state_next = ST_CHK1;
                        end
                    end
                end
            end

            ST_DIV0:
            begin
                if (div_done)
                begin
                    cw_next    = step - div_rem;
                    state_next = ST_CHK1;
                end
            end

            ST_CHK1:
            begin
                state_next = ST_CHK2;
                if (cond1)
                begin
                    rep_b1_next = 1'b1;
                    b1_pos_next = lbp_reg;
                    cls_next    = lbp_reg;
                    lw_next     = wsb_reg;
                    if (it_reg.is_tab)
                    begin
                        div_start  = 1'b1;
                        div_x      = wsb_reg;
                        state_next = ST_DIV1;
                    end
                end
            end

            ST_DIV1:
            begin
                if (div_done)
                begin
                    cw_next    = step - div_rem;
                    state_next = ST_CHK2;
                end
            end

            ST_CHK2:
            begin
                if (cond2)
                begin
                    rep_b2_next = 1'b1;
                    cls_next    = cur_pos_reg;
                    lbp_next    = cur_pos_reg;
                end
                lw_next = sat_line_width(lw_sum);
                if (it_reg.is_brk)
                begin
                    lbp_next = cur_pos_reg + PW'(1);
                    wsb_next = '0;
                end
                else
                begin
                    wsb_next = sat_line_width(wsb_sum);
                end
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (slot_free)
                begin
                    if (any_rep)
                    begin
                        if (rep_s_reg)
                        begin
                            rep_s_next = 1'b0;
                        end
                        else if (rep_b1_reg)
                        begin
                            rep_b1_next = 1'b0;
                        end
                        else
                        begin
                            rep_b2_next = 1'b0;
                        end
                        if (lines_reg < CW'(MAX_LINE_STARTS))
                        begin
                            out_load    = 1'b1;
                            kind_next   = KIND_START;
                            start_next  = sel_pos;
                            number_next = lines_reg[NW-1:0];
                            last_next   = !(it_reg.eot || (sel_later &&
                                          (lines_reg < CW'(MAX_LINE_STARTS - 1))));
                            lines_next  = lines_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        if (it_reg.eot)
                        begin
                            out_load     = 1'b1;
                            kind_next    = KIND_COUNT;
                            count_next   = lines_reg;
                            last_next    = 1'b1;
                            pos_next     = '0;
                            cls_next     = '0;
                            lbp_next     = '0;
                            lw_next      = '0;
                            wsb_next     = '0;
                            pending_next = 1'b1;
                            lines_next   = '0;
                        end
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wrap_reg      <= WRAP_RESET;
            max_width_reg <= MAXW_RESET;
            space_reg     <= SPACE_RESET;
            pos_reg       <= '0;
            lw_reg        <= '0;
            wsb_reg       <= '0;
            lbp_reg       <= '0;
            cls_reg       <= '0;
            pending_reg   <= 1'b1;
            lines_reg     <= '0;
            rep_s_reg     <= 1'b0;
            rep_b1_reg    <= 1'b0;
            rep_b2_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wrap_reg      <= wrap_next;
            max_width_reg <= max_width_next;
            space_reg     <= space_next;
            pos_reg       <= pos_next;
            lw_reg        <= lw_next;
            wsb_reg       <= wsb_next;
            lbp_reg       <= lbp_next;
            cls_reg       <= cls_next;
            pending_reg   <= pending_next;
            lines_reg     <= lines_next;
            rep_s_reg     <= rep_s_next;
            rep_b1_reg    <= rep_b1_next;
            rep_b2_reg    <= rep_b2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        it_reg      <= it_next;
        cur_pos_reg <= cur_pos_next;
        b1_pos_reg  <= b1_pos_next;
        cw_reg      <= cw_next;
        if (out_load)
        begin
            kind_reg   <= kind_next;
            start_reg  <= start_next;
            number_reg <= number_next;
            count_reg  <= count_next;
            last_reg   <= last_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign line_start  = start_reg;
    assign line_number = number_reg;
    assign line_count  = count_reg;
    assign last        = last_reg;

endmodule

FILE: sv/greedy_line_breaker.sv
// Top level of the greedy word-wrap line breaker.
// Depends on glb_pkg, glb_front, glb_fifo and glb_back.
//
// Input channel: one character beat (char_code, char_width, end_of_text)
// under in_valid/in_ready. Output channel: result beats under
// out_valid/out_ready; kind selects a line-start report (line_start,
// line_number) or the end-of-text count (line_count); last marks the final
// result caused by one character. Configuration: cfg_write with cfg_index
// and cfg_data, written while no text is in flight.
// A two-entry queue sits behind the input, so the sender is held only when
// it is full. A plain character passes the back-end states IDLE, CHK1, CHK2 and EMIT,
// staying in EMIT for each line-start report it causes; a tab also waits in DIV0, and
// in DIV1 when the line breaks at the last break character, for the 16-step serial
// remainder unit. The first result of a plain character is loaded into the output
// register in EMIT, after the queue, IDLE, CHK1 and CHK2. A stalled receiver holds
// the result in the output register and holds the back end in EMIT; the queue keeps
// taking beats until it is full. Reset clears the text state (first line pending)
// and loads the register defaults: wrap on, max width 32767, space width 7.
module greedy_line_breaker #(
    parameter int MAX_LINE_STARTS = glb_pkg::GLB_MAX_LINE_STARTS,
    parameter int MAX_TEXT_LENGTH = glb_pkg::GLB_MAX_TEXT_LENGTH,
    parameter int TAB_SPACES      = glb_pkg::GLB_TAB_SPACES
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [glb_pkg::CHAR_W-1:0]           char_code,
    input  logic [glb_pkg::CHAR_W-1:0]           char_width,
    input  logic                                 end_of_text,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 kind,
    output logic [$clog2(MAX_TEXT_LENGTH+1)-1:0] line_start,
    output logic [$clog2(MAX_LINE_STARTS)-1:0]   line_number,
    output logic [$clog2(MAX_LINE_STARTS+1)-1:0] line_count,
    output logic                                 last,
    input  logic                                 cfg_write,
    input  logic [glb_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [glb_pkg::CFG_W-1:0]            cfg_data
);
    import glb_pkg::*;

    glb_item_t push_item;
    glb_item_t head;
    logic      push;
    logic      fifo_full;
    logic      pop;
    logic      empty;

    glb_front u_front (
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .char_code   (char_code),
        .char_width  (char_width),
        .end_of_text (end_of_text),
        .fifo_full   (fifo_full),
        .push        (push),
        .push_item   (push_item)
    );

    glb_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (fifo_full),
        .pop       (pop),
        .pop_item  (head),
        .empty     (empty)
    );

    glb_back #(
        .MAX_LINE_STARTS (MAX_LINE_STARTS),
        .MAX_TEXT_LENGTH (MAX_TEXT_LENGTH),
        .TAB_SPACES      (TAB_SPACES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .empty       (empty),
        .pop         (pop),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .line_start  (line_start),
        .line_number (line_number),
        .line_count  (line_count),
        .last        (last)
    );

endmodule

FILE: sv/glb_checker.sv
// Port-level checker for the greedy line breaker, bound to the top level.
// Depends on glb_pkg and greedy_line_breaker_defines.svh.
`include "greedy_line_breaker_defines.svh"

module glb_checker #(
    parameter int MAX_LINE_STARTS = glb_pkg::GLB_MAX_LINE_STARTS,
    parameter int MAX_TEXT_LENGTH = glb_pkg::GLB_MAX_TEXT_LENGTH
) (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic                                 kind,
    input logic [$clog2(MAX_TEXT_LENGTH+1)-1:0] line_start,
    input logic [$clog2(MAX_LINE_STARTS)-1:0]   line_number,
    input logic [$clog2(MAX_LINE_STARTS+1)-1:0] line_count,
    input logic                                 last
);
    import glb_pkg::*;

    `GLB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(kind) && $stable(line_start) && $stable(line_number) && $stable(line_count) && $stable(last), "stalled result beat changed")
    `GLB_ASSERT_IMPLIES(a_count_form, clk, rst_n, out_valid && (kind == KIND_COUNT), last && (line_start == '0) && (line_number == '0), "count beat malformed")
    `GLB_ASSERT_IMPLIES(a_start_form, clk, rst_n, out_valid && (kind == KIND_START), line_count == '0, "line-start beat carries a count")
    `GLB_ASSERT_NEXT(a_text_restart, clk, rst_n, out_valid && out_ready && (kind == KIND_COUNT), !out_valid || ((kind == KIND_START) && (line_start == '0) && (line_number == '0)), "new text does not open with line zero")

endmodule

bind greedy_line_breaker glb_checker #(
    .MAX_LINE_STARTS (MAX_LINE_STARTS),
    .MAX_TEXT_LENGTH (MAX_TEXT_LENGTH)
) u_glb_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .line_start  (line_start),
    .line_number (line_number),
    .line_count  (line_count),
    .last        (last)
);
